/* hw/rtl/bctc_pkg.sv */
// shared constants and types for the broadcast tree children block
package bctc_pkg;

  localparam int NODES_MAX_DEF = 1024;
  localparam int K_MAX_DEF     = 4;
  localparam int MAX_RESULTS   = 32;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam int RANK_W        = 10;
  localparam int DELAY_K_W     = 3;
  localparam int NODE_COUNT_W  = 11;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [DELAY_K_W-1:0]    DELAY_K_RESET    = 3'd1;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELAY_K    = 1'b0,
    REG_NODE_COUNT = 1'b1
  } cfg_reg_t;

  // sequencer command to the recurrence unit
  typedef struct packed {
    logic clear;
    logic advance;
  } fstep_t;

endpackage

/* hw/rtl/bctc_fib_unit.sv */
// shared saturating adder and history window that walk the lagged recurrence
module bctc_fib_unit #(
  parameter int NODES_MAX = bctc_pkg::NODES_MAX_DEF,
  parameter int K_MAX     = bctc_pkg::K_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bctc_pkg::fstep_t                 step,
  input  logic [$clog2(K_MAX + 1)-1:0]     k,
  output logic [$clog2(NODES_MAX + 1)-1:0] value
);

  localparam int FW = $clog2(NODES_MAX + 1);
  localparam int KW = $clog2(K_MAX + 1);

  // w_r[j] holds f(t-1-j)
  logic [FW-1:0] w_r [K_MAX];
  logic [KW-1:0] tcnt_r, tcnt_nxt;
  logic [FW-1:0] tap;
  logic [FW:0]   sum;

  always_comb begin
    tap = '0;
    for (int j = 0; j < K_MAX; j++) begin
      if (KW'(j + 1) == k) tap = w_r[j];
    end
    sum = {1'b0, w_r[0]} + {1'b0, tap};
    if (tcnt_r < k) begin
      value = FW'(1);
    end else if (sum > (FW + 1)'(NODES_MAX)) begin
      value = FW'(NODES_MAX);
    end else begin
      value = sum[FW-1:0];
    end
  end

  always_comb begin
    tcnt_nxt = tcnt_r;
    if (step.clear) begin
      tcnt_nxt = '0;
    end else if (step.advance && (tcnt_r < KW'(K_MAX))) begin
      tcnt_nxt = tcnt_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcnt_r <= '0;
    end else begin
      tcnt_r <= tcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.advance) begin
      w_r[0] <= value;
      for (int j = 1; j < K_MAX; j++) begin
        w_r[j] <= w_r[j-1];
      end
    end
  end

endmodule

/* hw/rtl/broadcast_tree_children_top.sv */
// top level of the broadcast tree children block: sequencer, output register, config
// For each sender word taken, the block lists the ranks that sender sends to in a
// lagged-fibonacci (lame) broadcast tree, one output word per child in send order, the
// final one marked by out_is_last. A sender at or above the node count, or with no
// child below it, produces no words. One sender is worked on at a time and in_stall is
// high until its last child is loaded into the output register. The sequence terms are
// made one per cycle by a single saturating adder, except while a held child waits on a
// stalled output register. A sender at or above the node count is dropped in the cycle
// it is taken. delay_k and node_count are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block does not enforce;
// delay_k of zero acts as one and values above K_MAX act as K_MAX, node_count above
// NODES_MAX acts as NODES_MAX.
module broadcast_tree_children_top #(
  parameter int NODES_MAX = bctc_pkg::NODES_MAX_DEF,
  parameter int K_MAX     = bctc_pkg::K_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bctc_pkg::RANK_W-1:0]        in_sender_rank,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bctc_pkg::RANK_W-1:0]        out_child_rank,
  output logic                               out_is_last,
  // config write port
  input  logic                               cfg_we,
  input  logic [bctc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bctc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FW     = $clog2(NODES_MAX + 1);
  localparam int KW     = $clog2(K_MAX + 1);
  localparam int RANK_W = bctc_pkg::RANK_W;
  localparam int CNT_W  = bctc_pkg::CNT_W;
  // compare width: holds sender + f and the node count without overflow
  localparam int CW     = ((FW > bctc_pkg::NODE_COUNT_W) ? FW : bctc_pkg::NODE_COUNT_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEEK,
    S_CHILD,
    S_FLUSH
  } state_t;

  // config registers
  logic [bctc_pkg::DELAY_K_W-1:0]    delay_k_r;
  logic [bctc_pkg::NODE_COUNT_W-1:0] node_count_r;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [RANK_W-1:0] sender_r, sender_nxt;
  logic [KW-1:0]     skip_r, skip_nxt;
  logic [RANK_W-1:0] pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0] out_child_r, out_child_nxt;
  logic              out_last_r, out_last_nxt;

  bctc_pkg::fstep_t  step;
  logic [FW-1:0]     fib_value;
  logic [KW-1:0]     k_eff;
  logic [CW-1:0]     n_eff;
  logic [CW-1:0]     sender_ext;
  logic [CW-1:0]     value_ext;
  logic [CW-1:0]     child_sum;
  logic              child_ok;
  logic              slot_free;

  // effective lag, clamped to 1..K_MAX
  always_comb begin
    if (delay_k_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(delay_k_r) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(delay_k_r);
    end
  end

  // effective node count, clamped to NODES_MAX
  always_comb begin
    if (CW'(node_count_r) > CW'(NODES_MAX)) begin
      n_eff = CW'(NODES_MAX);
    end else begin
      n_eff = CW'(node_count_r);
    end
  end

  // the recurrence unit: produces f(t) for the current t each cycle
  bctc_fib_unit #(
    .NODES_MAX (NODES_MAX),
    .K_MAX     (K_MAX)
  ) u_fib (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .k     (k_eff),
    .value (fib_value)
  );

  assign sender_ext = CW'(sender_r);
  assign value_ext  = CW'(fib_value);
  assign child_sum  = sender_ext + value_ext;
  assign child_ok   = child_sum < n_eff;
  // output register can take a word this cycle
  assign slot_free  = !out_valid_r || !out_stall;

  // sequencer
  // seek: walk t up until f(t) > sender (start level s)
  // child: skip k-1 more terms, then one child per term while below the node count, up to MAX_RESULTS;
  //        each child is held one step so the final one can be marked
  // flush: hand over the held child marked last
  always_comb begin
    state_nxt     = state_r;
    sender_nxt    = sender_r;
    skip_nxt      = skip_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_child_nxt = out_child_r;
    out_last_nxt  = out_last_r;
    step          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // senders outside the tree are taken and dropped
          if (CW'(in_sender_rank) < n_eff) begin
            state_nxt  = S_SEEK;
            sender_nxt = in_sender_rank;
            pend_v_nxt = 1'b0;
            cnt_nxt    = '0;
            step.clear = 1'b1;
          end
        end
      end
      S_SEEK: begin
        if ((sender_r == '0) || (value_ext > sender_ext)) begin
          // hold t at s; child phase starts from f(s)
          state_nxt = S_CHILD;
          skip_nxt  = k_eff - KW'(1);
        end else begin
          step.advance = 1'b1;
        end
      end
      S_CHILD: begin
        if (skip_r != '0) begin
          step.advance = 1'b1;
          skip_nxt     = skip_r - KW'(1);
        end else if (!child_ok) begin
          state_nxt = pend_v_r ? S_FLUSH : S_IDLE;
        end else if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_child_nxt = pend_r;
            out_last_nxt  = 1'b0;
          end
          pend_nxt     = child_sum[RANK_W-1:0];
          pend_v_nxt   = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          step.advance = 1'b1;
          // result limit reached, remaining children dropped
          if (cnt_r == CNT_W'(bctc_pkg::MAX_RESULTS - 1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_child_nxt = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload, no reset needed
    sender_r    <= sender_nxt;
    pend_r      <= pend_nxt;
    out_child_r <= out_child_nxt;
    out_last_r  <= out_last_nxt;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_k_r    <= bctc_pkg::DELAY_K_RESET;
      node_count_r <= bctc_pkg::NODE_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (bctc_pkg::cfg_reg_t'(cfg_index))
        bctc_pkg::REG_DELAY_K: begin
          delay_k_r <= cfg_data[bctc_pkg::DELAY_K_W-1:0];
        end
        bctc_pkg::REG_NODE_COUNT: begin
          node_count_r <= cfg_data[bctc_pkg::NODE_COUNT_W-1:0];
        end
        default: begin
          delay_k_r <= delay_k_r;
        end
      endcase
    end
  end

  // one sender at a time
  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_child_rank = out_child_r;
  assign out_is_last    = out_last_r;

endmodule

/* hw/rtl/bctc_checker.sv */
// port-level checks for the broadcast tree children block, bound to the top level
module bctc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [bctc_pkg::RANK_W-1:0]      out_child_rank,
  input logic                             out_is_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_child_rank) && $stable(out_is_last))
    else $error("result word changed while stalled");

  // while a non-final child waits, the final one is still owed, so no new sender
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> in_stall)
    else $error("sender taken before its last child was produced");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not quiet after reset");

endmodule

bind broadcast_tree_children_top bctc_checker u_bctc_checker (.*);
